FILE: rtl/tfc_pkg.sv
// Shared types, constants and tables for the ATA PIO task file controller.
// No dependencies.
package tfc_pkg;

	localparam int SECTOR_WORDS = 256;
	localparam int ADDR_W = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;

	localparam logic [1:0] OP_REG_WR = 2'd0;
	localparam logic [1:0] OP_REG_RD = 2'd1;
	localparam logic [1:0] OP_FILL   = 2'd2;
	localparam logic [1:0] OP_DRAIN  = 2'd3;

	localparam logic [2:0] REG_DATA  = 3'd0;
	localparam logic [2:0] REG_ERR   = 3'd1;
	localparam logic [2:0] REG_COUNT = 3'd2;
	localparam logic [2:0] REG_SECT  = 3'd3;
	localparam logic [2:0] REG_CYLLO = 3'd4;
	localparam logic [2:0] REG_CYLHI = 3'd5;
	localparam logic [2:0] REG_HEAD  = 3'd6;
	localparam logic [2:0] REG_CMD   = 3'd7;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_COMMIT = 2'd2;
	localparam logic [1:0] KIND_IDENT  = 2'd3;

	localparam logic [7:0] CMD_NONE   = 8'h00;
	localparam logic [7:0] CMD_READ0  = 8'h20;
	localparam logic [7:0] CMD_READ1  = 8'h21;
	localparam logic [7:0] CMD_WRITE0 = 8'h30;
	localparam logic [7:0] CMD_WRITE1 = 8'h31;
	localparam logic [7:0] CMD_IDENT  = 8'hEC;
	localparam logic [7:0] CMD_DIAG   = 8'h90;

	localparam logic [7:0] ST_BUSY = 8'h80;
	localparam logic [7:0] ST_RDY  = 8'h40;
	localparam logic [7:0] ST_DRQ  = 8'h08;
	localparam logic [7:0] ST_DIAG = 8'h50;

	localparam logic [1:0] CFG_DRIVE0 = 2'd0;
	localparam logic [1:0] CFG_DRIVE1 = 2'd1;
	localparam logic [1:0] CFG_POLLS  = 2'd2;

	localparam logic [7:0] BUSY_POLLS_RST = 8'd4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef addr_t pos_table_t [256];

	function automatic pos_table_t build_pos_table();
		pos_table_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = addr_t'(i % SECTOR_WORDS);
		end
		return t;
	endfunction

	localparam pos_table_t POS_TABLE = build_pos_table();

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  reg_index;
		logic [15:0] write_data;
		logic [7:0]  buffer_word;
	} item_t;

	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic        rd;
		logic        wr;
		logic        clr;
		addr_t       addr;
		logic [15:0] wdata;
	} buf_req_t;

	typedef struct packed {
		logic        from_mem;
		logic [15:0] rdata;
		logic [1:0]  kind;
		logic [27:0] lba;
		logic        drive;
	} res_t;

endpackage

FILE: rtl/tfc_if.sv
// Word channels of the task file controller: bus/media items in, results out.
// No dependencies.
interface tfc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [2:0]  reg_index;
	logic [15:0] write_data;
	logic [7:0]  buffer_word;

	modport source(output valid, output opcode, output reg_index, output write_data,
		output buffer_word, input ready);
	modport sink(input valid, input opcode, input reg_index, input write_data,
		input buffer_word, output ready);
endinterface

interface tfc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic [1:0]  request_kind;
	logic [27:0] request_lba;
	logic        request_drive;

	modport source(output valid, output read_data, output request_kind,
		output request_lba, output request_drive, input ready);
	modport sink(input valid, input read_data, input request_kind,
		input request_lba, input request_drive, output ready);
endinterface

FILE: rtl/ata_pio_task_file_controller.sv
// ATA PIO task file controller, two drives, shared sector buffer.
// The result word is valid in the cycle after its item word is accepted.
// Throughput: one item per cycle; the single result register sets the pace, and the input
// drops ready while a result word waits and the sink stalls.
// Reset (arst_n, asynchronous): task file cleared, no command, busy count 4.
module ata_pio_task_file_controller (
	input  logic               clk,
	input  logic               arst_n,
	tfc_item_if.sink           item,
	tfc_result_if.source       result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import tfc_pkg::*;

	logic     accept;
	logic     out_valid_q;
	item_t    item_w;
	cfg_wr_t  cfg_w;
	buf_req_t buf_req;
	res_t     res_s1;
	logic [15:0] buf_rdata;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign item_w = '{opcode: item.opcode, reg_index: item.reg_index,
		write_data: item.write_data, buffer_word: item.buffer_word};
	assign cfg_w  = '{we: cfg_we, index: cfg_index, data: cfg_data};

	tfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item_w),
		.cfg     (cfg_w),
		.buf_req (buf_req),
		.res_s1  (res_s1)
	);

	tfc_buffer u_buffer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (buf_req),
		.rdata  (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.read_data     = res_s1.from_mem ? buf_rdata : res_s1.rdata;
	assign result.request_kind  = res_s1.kind;
	assign result.request_lba   = res_s1.lba;
	assign result.request_drive = res_s1.drive;

endmodule

FILE: rtl/tfc_buffer.sv
// Sector buffer: single-port synchronous RAM with per-word valid bits for the
// bulk clear issued by transfer commands. Depends on tfc_pkg.
module tfc_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  tfc_pkg::buf_req_t req,
	output logic [15:0]       rdata
);
	import tfc_pkg::*;

	logic [15:0]             mem [SECTOR_WORDS];
	logic [SECTOR_WORDS-1:0] valid_q;
	logic [15:0]             rdata_s1;
	logic                    hit_s1;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_s1 <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				hit_s1 <= valid_q[req.addr];
			end
		end
	end

	assign rdata = hit_s1 ? rdata_s1 : 16'd0;

endmodule

FILE: rtl/tfc_regs.sv
// Task file registers, command decode, data port pointer and busy countdown.
// Drives the sector buffer requests and the registered result. Depends on tfc_pkg.
module tfc_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tfc_pkg::item_t    item,
	input  tfc_pkg::cfg_wr_t  cfg,
	output tfc_pkg::buf_req_t buf_req,
	output tfc_pkg::res_t     res_s1
);
	import tfc_pkg::*;

	logic [7:0] count_q, sect_q, cyllo_q, cylhi_q, head_q, cmd_q;
	logic [7:0] busy_q, polls_q;
	addr_t      ptr_q;
	logic       len_q;
	logic [1:0] present_q;
	logic [7:0] status_q [2];
	logic [1:0] err_q;

	logic       drv;
	logic [7:0] wbyte;
	logic       is_wr, is_rd, data_acc, ptr_last, xfer_end, cmd_wr, open_xfer, diag;
	logic       stat_busy;
	res_t       res_d;

	always_comb begin
		drv       = head_q[4];
		wbyte     = item.write_data[7:0];
		is_wr     = (item.opcode == OP_REG_WR);
		is_rd     = (item.opcode == OP_REG_RD);
		data_acc  = (is_wr || is_rd) && (item.reg_index == REG_DATA) && (cmd_q != CMD_NONE);
		ptr_last  = (ptr_q == addr_t'(SECTOR_WORDS - 1));
		xfer_end  = data_acc && (!len_q || ptr_last);
		cmd_wr    = is_wr && (item.reg_index == REG_CMD);
		open_xfer = cmd_wr && (wbyte == CMD_READ0 || wbyte == CMD_READ1 ||
			wbyte == CMD_WRITE0 || wbyte == CMD_WRITE1 || wbyte == CMD_IDENT);
		diag      = cmd_wr && (wbyte == CMD_DIAG);
		stat_busy = is_rd && (item.reg_index == REG_CMD) && (busy_q != 8'd0);

		buf_req.rd    = accept && ((item.opcode == OP_DRAIN) || (is_rd && data_acc));
		buf_req.wr    = accept && ((item.opcode == OP_FILL) || (is_wr && data_acc));
		buf_req.clr   = accept && open_xfer;
		buf_req.addr  = (item.opcode == OP_FILL || item.opcode == OP_DRAIN) ?
			POS_TABLE[item.buffer_word] : ptr_q;
		buf_req.wdata = item.write_data;

		res_d.from_mem = (item.opcode == OP_DRAIN) || (is_rd && data_acc);
		res_d.rdata    = 16'd0;
		res_d.kind     = KIND_NONE;
		if (is_rd) begin
			unique case (item.reg_index)
				REG_DATA:  res_d.rdata = 16'd0;
				REG_ERR:   res_d.rdata = {15'd0, err_q[drv]};
				REG_COUNT: res_d.rdata = {8'd0, count_q};
				REG_SECT:  res_d.rdata = {8'd0, sect_q};
				REG_CYLLO: res_d.rdata = {8'd0, cyllo_q};
				REG_CYLHI: res_d.rdata = {8'd0, cylhi_q};
				REG_HEAD:  res_d.rdata = {8'd0, head_q};
				REG_CMD:   res_d.rdata = {8'd0, stat_busy ? ST_BUSY : status_q[drv]};
				default:   res_d.rdata = 16'd0;
			endcase
		end
		if (cmd_wr) begin
			if (wbyte == CMD_IDENT) begin
				res_d.kind = KIND_IDENT;
			end else if (wbyte == CMD_READ0 || wbyte == CMD_READ1) begin
				res_d.kind = KIND_READ;
			end
		end else if (is_wr && xfer_end && (cmd_q == CMD_WRITE0 || cmd_q == CMD_WRITE1)) begin
			res_d.kind = KIND_COMMIT;
		end
		res_d.lba   = (res_d.kind != KIND_NONE) ? {head_q[3:0], cylhi_q, cyllo_q, sect_q} : 28'd0;
		res_d.drive = (res_d.kind != KIND_NONE) ? drv : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sect_q      <= '0;
			cyllo_q     <= '0;
			cylhi_q     <= '0;
			head_q      <= '0;
			cmd_q       <= CMD_NONE;
			ptr_q       <= '0;
			len_q       <= 1'b0;
			busy_q      <= BUSY_POLLS_RST;
			polls_q     <= BUSY_POLLS_RST;
			present_q   <= '0;
			status_q[0] <= '0;
			status_q[1] <= '0;
			err_q       <= '0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CFG_DRIVE0, CFG_DRIVE1: begin
					present_q[cfg.index[0]] <= cfg.data[0];
					if (cfg.data[0]) begin
						status_q[cfg.index[0]] <= ST_RDY;
						err_q[cfg.index[0]]    <= 1'b0;
					end
				end
				CFG_POLLS: polls_q <= cfg.data;
				default: ;
			endcase
		end else if (accept) begin
			if (is_wr) begin
				unique case (item.reg_index)
					REG_COUNT: count_q <= wbyte;
					REG_SECT:  sect_q  <= wbyte;
					REG_CYLLO: cyllo_q <= wbyte;
					REG_CYLHI: cylhi_q <= wbyte;
					REG_HEAD:  head_q  <= wbyte;
					REG_CMD:   cmd_q   <= wbyte;
					default: ;
				endcase
			end
			if (open_xfer) begin
				busy_q        <= polls_q;
				len_q         <= 1'b1;
				ptr_q         <= '0;
				status_q[drv] <= ST_DRQ | ST_RDY;
			end
			if (diag) begin
				for (int d = 0; d < 2; d++) begin
					err_q[d]    <= present_q[d];
					status_q[d] <= present_q[d] ? ST_DIAG : 8'd0;
				end
			end
			if (stat_busy) begin
				busy_q <= busy_q - 8'd1;
			end
			if (xfer_end) begin
				ptr_q         <= '0;
				len_q         <= 1'b0;
				cmd_q         <= CMD_NONE;
				status_q[drv] <= ST_RDY;
				err_q[drv]    <= 1'b0;
			end else if (data_acc) begin
				ptr_q <= ptr_q + addr_t'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= addr_t'(SECTOR_WORDS - 1))
		else $error("data pointer beyond sector");

	a_busy_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.we && stat_busy) |=> (busy_q == $past(busy_q) - 8'd1))
		else $error("busy countdown not decremented on busy poll");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.we && xfer_end) |=> (cmd_q == CMD_NONE && ptr_q == '0 && !len_q))
		else $error("transfer end did not clear command state");

	a_commit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_d.kind == KIND_COMMIT) |-> (is_wr && xfer_end))
		else $error("commit request outside a write transfer end");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for ata_pio_task_file_controller: a task file and buffer model
// predicts untyped results, driven by a directed table then random command sessions.
// Depends on tfc_pkg, tfc_item_if, tfc_result_if and the controller RTL.
module tb_top;
	import tfc_pkg::*;

	typedef struct packed {
		logic [15:0] rdata;
		logic [1:0]  kind;
		logic [27:0] lba;
		logic        drive;
	} result_word_t;

	typedef struct packed {
		logic [1:0]   opcode;
		logic [2:0]   reg_index;
		logic [15:0]  write_data;
		logic [7:0]   buffer_word;
		bit           typed;
		result_word_t res;
	} plan_row_t;

	typedef enum int {RX_OPEN, RX_EVERY_THIRD, RX_COIN, RX_BLOCKS} rx_mode_e;

	localparam logic [7:0] CMD_OTHER = 8'h5A;
	localparam logic [7:0] DIAG_PASS = 8'h01;
	localparam result_word_t QUIET = '{16'h0000, KIND_NONE, 28'h0, 1'b0};
	localparam int N_PLAN = 25;
	localparam int N_PHASES = 5;

	localparam plan_row_t PLAN [N_PLAN] = '{
		'{OP_REG_RD, REG_ERR,   16'h0000, 8'h00, 1'b1, QUIET},
		'{OP_REG_RD, REG_CMD,   16'h0000, 8'h00, 1'b1, '{16'h0080, KIND_NONE, 28'h0, 1'b0}},
		'{OP_REG_RD, REG_DATA,  16'h0000, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_DATA,  16'hFFFF, 8'hFF, 1'b1, QUIET},
		'{OP_REG_WR, REG_CMD,   {8'h00, CMD_OTHER}, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_DATA,  16'h0000, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_ERR,   16'hFFFF, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_COUNT, 16'hFFFF, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_SECT,  16'h00FF, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_CYLLO, 16'hFFFF, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_CYLHI, 16'hFFFF, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_HEAD,  16'h00FF, 8'h00, 1'b1, QUIET},
		'{OP_REG_RD, REG_HEAD,  16'h0000, 8'h00, 1'b1, '{16'h00FF, KIND_NONE, 28'h0, 1'b0}},
		'{OP_REG_WR, REG_CMD,   {8'h00, CMD_IDENT}, 8'h00, 1'b1,
			'{16'h0000, KIND_IDENT, 28'hFFFFFFF, 1'b1}},
		'{OP_DRAIN,  REG_DATA,  16'h0000, 8'hFF, 1'b1, QUIET},
		'{OP_FILL,   REG_DATA,  16'hFFFF, 8'h00, 1'b1, QUIET},
		'{OP_REG_RD, REG_DATA,  16'h0000, 8'h00, 1'b1, '{16'hFFFF, KIND_NONE, 28'h0, 1'b0}},
		'{OP_REG_RD, REG_CMD,   16'h0000, 8'h00, 1'b0, QUIET},
		'{OP_REG_WR, REG_HEAD,  16'h0000, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_CMD,   {8'h00, CMD_WRITE1}, 8'h00, 1'b1, QUIET},
		'{OP_REG_WR, REG_DATA,  16'hA5A5, 8'h00, 1'b0, QUIET},
		'{OP_REG_WR, REG_CMD,   {8'h00, CMD_DIAG}, 8'h00, 1'b0, QUIET},
		'{OP_REG_RD, REG_ERR,   16'h0000, 8'h00, 1'b0, QUIET},
		'{OP_REG_WR, REG_CMD,   {8'h00, CMD_READ0}, 8'h00, 1'b0, QUIET},
		'{OP_DRAIN,  REG_DATA,  16'h0000, 8'h80, 1'b0, QUIET}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	tfc_item_if   req_ch();
	tfc_result_if rsp_ch();

	ata_pio_task_file_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(req_ch),
		.result(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// task file model
	logic [7:0]  tf_count, tf_sector, tf_cyl_lo, tf_cyl_hi, tf_head;
	logic [7:0]  cmd_now, busy_left, poll_limit;
	logic [8:0]  wptr;
	bit          xfer_open;
	bit          present [2];
	logic [7:0]  drv_status [2];
	logic [7:0]  drv_error [2];
	logic [15:0] sbuf [SECTOR_WORDS];
	bit          known [SECTOR_WORDS];

	result_word_t pending_results [$];
	result_word_t got_front;
	int n_sent, n_checked, n_bad, n_xfer_done, n_commits;
	int burst_left;
	bit sending;
	int rx_tick;
	rx_mode_e rx_mode;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic item_t mk(input logic [1:0] op, input logic [2:0] r,
		input logic [15:0] d, input logic [7:0] p);
		return '{op, r, d, p};
	endfunction

	// moves the data port on; true when the command ends
	function automatic bit step_pointer();
		wptr = wptr + 9'd1;
		if (!xfer_open || wptr >= SECTOR_WORDS) begin
			if (xfer_open)
				n_xfer_done++;
			wptr = '0;
			xfer_open = 0;
			cmd_now = CMD_NONE;
			drv_status[tf_head[4]] = ST_RDY;
			drv_error[tf_head[4]] = '0;
			return 1;
		end
		return 0;
	endfunction

	task automatic task_file_step(input item_t w, output result_word_t e);
		logic [7:0] b;
		logic [7:0] cmd_was;
		b = w.write_data[7:0];
		cmd_was = cmd_now;
		e = QUIET;
		case (w.opcode)
		OP_REG_WR: begin
			case (w.reg_index)
			REG_DATA: begin
				if (cmd_now != CMD_NONE) begin
					sbuf[wptr % SECTOR_WORDS] = w.write_data;
					known[wptr % SECTOR_WORDS] = 1;
					if (step_pointer() && (cmd_was == CMD_WRITE0 || cmd_was == CMD_WRITE1))
						e.kind = KIND_COMMIT;
				end
			end
			REG_COUNT: tf_count = b;
			REG_SECT:  tf_sector = b;
			REG_CYLLO: tf_cyl_lo = b;
			REG_CYLHI: tf_cyl_hi = b;
			REG_HEAD:  tf_head = b;
			REG_CMD: begin
				cmd_now = b;
				case (b)
				CMD_DIAG: begin
					for (int d = 0; d < 2; d++) begin
						drv_error[d] = present[d] ? DIAG_PASS : 8'h00;
						drv_status[d] = present[d] ? ST_DIAG : 8'h00;
					end
				end
				CMD_IDENT, CMD_READ0, CMD_READ1, CMD_WRITE0, CMD_WRITE1: begin
					busy_left = poll_limit;
					xfer_open = 1;
					wptr = '0;
					drv_status[tf_head[4]] = ST_DRQ | ST_RDY;
					for (int i = 0; i < SECTOR_WORDS; i++) begin
						sbuf[i] = '0;
						known[i] = 1;
					end
					if (b == CMD_IDENT)
						e.kind = KIND_IDENT;
					else if (b == CMD_READ0 || b == CMD_READ1)
						e.kind = KIND_READ;
				end
				default: ;
				endcase
			end
			default: ;
			endcase
		end
		OP_REG_RD: begin
			case (w.reg_index)
			REG_DATA: begin
				if (cmd_now != CMD_NONE) begin
					e.rdata = sbuf[wptr % SECTOR_WORDS];
					void'(step_pointer());
				end
			end
			REG_ERR:   e.rdata = {8'h00, drv_error[tf_head[4]]};
			REG_COUNT: e.rdata = {8'h00, tf_count};
			REG_SECT:  e.rdata = {8'h00, tf_sector};
			REG_CYLLO: e.rdata = {8'h00, tf_cyl_lo};
			REG_CYLHI: e.rdata = {8'h00, tf_cyl_hi};
			REG_HEAD:  e.rdata = {8'h00, tf_head};
			default: begin
				if (busy_left != 0) begin
					busy_left = busy_left - 8'd1;
					e.rdata = {8'h00, ST_BUSY};
				end else begin
					e.rdata = {8'h00, drv_status[tf_head[4]]};
				end
			end
			endcase
		end
		OP_FILL: begin
			sbuf[w.buffer_word % SECTOR_WORDS] = w.write_data;
			known[w.buffer_word % SECTOR_WORDS] = 1;
		end
		default: e.rdata = sbuf[w.buffer_word % SECTOR_WORDS];
		endcase
		if (e.kind != KIND_NONE) begin
			e.lba = {tf_head[3:0], tf_cyl_hi, tf_cyl_lo, tf_sector};
			e.drive = tf_head[4];
			if (e.kind == KIND_COMMIT)
				n_commits++;
		end
	endtask

	task automatic send_word(input item_t w_in, input bit typed, input result_word_t te);
		item_t w;
		result_word_t e;
		int gap;
		w = w_in;
		// never read a buffer word that has not been written since reset
		if (w.opcode == OP_DRAIN && !known[w.buffer_word % SECTOR_WORDS])
			w.opcode = OP_FILL;
		if (w.opcode == OP_REG_RD && w.reg_index == REG_DATA && cmd_now != CMD_NONE &&
			!known[wptr % SECTOR_WORDS])
			w.opcode = OP_REG_WR;
		task_file_step(w, e);
		if (typed)
			e = te;
		req_ch.valid <= 1'b1;
		req_ch.opcode <= w.opcode;
		req_ch.reg_index <= w.reg_index;
		req_ch.write_data <= w.write_data;
		req_ch.buffer_word <= w.buffer_word;
		sending = 1;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(e);
		n_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 16);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				sending = 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_POLLS) begin
			poll_limit = val;
		end else begin
			present[idx[0]] = val[0];
			if (val[0]) begin
				drv_status[idx[0]] = ST_RDY;
				drv_error[idx[0]] = '0;
			end
		end
	endtask

	task automatic hold_until_drained();
		if (sending) begin
			req_ch.valid <= 1'b0;
			sending = 0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// task file setup, one command, status polls, a run of mostly data port words, then random words
	task automatic run_session();
		logic [7:0] code;
		int pick;
		int left;
		bit full_run;
		bit host_writes;
		full_run = ($urandom_range(0, 3) == 0);
		for (int r = REG_COUNT; r <= REG_HEAD; r++) begin
			if ($urandom_range(0, 5) != 0)
				send_word(mk(OP_REG_WR, 3'(r), 16'($urandom), 8'($urandom)), 0, QUIET);
		end
		pick = $urandom_range(0, 19);
		if (full_run) begin
			if (pick < 10)
				code = pick[0] ? CMD_WRITE1 : CMD_WRITE0;
			else if (pick < 15)
				code = pick[0] ? CMD_READ1 : CMD_READ0;
			else if (pick < 18)
				code = CMD_IDENT;
			else if (pick == 18)
				code = CMD_DIAG;
			else
				code = 8'($urandom);
		end else begin
			if (pick < 4)
				code = pick[0] ? CMD_WRITE1 : CMD_WRITE0;
			else if (pick < 8)
				code = pick[0] ? CMD_READ1 : CMD_READ0;
			else if (pick < 11)
				code = CMD_IDENT;
			else if (pick < 14)
				code = CMD_DIAG;
			else if (pick < 16)
				code = CMD_NONE;
			else
				code = 8'($urandom);
		end
		send_word(mk(OP_REG_WR, REG_CMD, {8'($urandom), code}, 8'($urandom)), 0, QUIET);
		repeat ($urandom_range(0, 6))
			send_word(mk(OP_REG_RD, REG_CMD, 16'($urandom), 8'($urandom)), 0, QUIET);
		host_writes = (code == CMD_WRITE0 || code == CMD_WRITE1) ?
			($urandom_range(0, 7) != 0) : ($urandom_range(0, 5) == 0);
		left = full_run ? 400 : $urandom_range(1, 24);
		while (left > 0 && !(full_run && cmd_now == CMD_NONE)) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_word(mk($urandom_range(0, 1) ? OP_FILL : OP_DRAIN, 3'($urandom),
					16'($urandom), 8'($urandom)), 0, QUIET);
			else if (pick == 1)
				send_word(mk(OP_REG_RD, 3'($urandom_range(1, 7)), 16'($urandom),
					8'($urandom)), 0, QUIET);
			else
				send_word(mk(host_writes ? OP_REG_WR : OP_REG_RD, REG_DATA, 16'($urandom),
					8'($urandom)), 0, QUIET);
			left--;
		end
		repeat ($urandom_range(0, 3))
			send_word(mk(2'($urandom), 3'($urandom), 16'($urandom), 8'($urandom)), 0, QUIET);
	endtask

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0)
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
		RX_OPEN:        rsp_ch.ready <= 1'b1;
		RX_EVERY_THIRD: rsp_ch.ready <= (rx_tick % 3 != 0);
		RX_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
		default:        rsp_ch.ready <= rx_tick[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: read_data %h kind %0d",
					rsp_ch.read_data, rsp_ch.request_kind);
				n_bad++;
			end else begin
				got_front = pending_results.pop_front();
				n_checked++;
				if (rsp_ch.read_data !== got_front.rdata) begin
					$error("read_data: expected %h, got %h", got_front.rdata, rsp_ch.read_data);
					n_bad++;
				end
				if (rsp_ch.request_kind !== got_front.kind) begin
					$error("request_kind: expected %0d, got %0d", got_front.kind,
						rsp_ch.request_kind);
					n_bad++;
				end
				if (rsp_ch.request_lba !== got_front.lba) begin
					$error("request_lba: expected %h, got %h", got_front.lba, rsp_ch.request_lba);
					n_bad++;
				end
				if (rsp_ch.request_drive !== got_front.drive) begin
					$error("request_drive: expected %0d, got %0d", got_front.drive,
						rsp_ch.request_drive);
					n_bad++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$error("timeout with %0d result words outstanding", pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_REG_RD;
		req_ch.reg_index = REG_DATA;
		req_ch.write_data = '0;
		req_ch.buffer_word = '0;
		rsp_ch.ready = 1'b0;
		rx_tick = 0;
		rx_mode = RX_OPEN;
		sending = 0;
		burst_left = 0;
		n_sent = 0;
		n_checked = 0;
		n_bad = 0;
		n_xfer_done = 0;
		n_commits = 0;
		tf_count = '0;
		tf_sector = '0;
		tf_cyl_lo = '0;
		tf_cyl_hi = '0;
		tf_head = '0;
		cmd_now = CMD_NONE;
		wptr = '0;
		xfer_open = 0;
		busy_left = BUSY_POLLS_RST;
		poll_limit = BUSY_POLLS_RST;
		for (int d = 0; d < 2; d++) begin
			present[d] = 0;
			drv_status[d] = '0;
			drv_error[d] = '0;
		end
		for (int i = 0; i < SECTOR_WORDS; i++) begin
			sbuf[i] = '0;
			known[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_PLAN; i++)
			send_word(mk(PLAN[i].opcode, PLAN[i].reg_index, PLAN[i].write_data,
				PLAN[i].buffer_word), PLAN[i].typed, PLAN[i].res);

		for (int p = 0; p < N_PHASES; p++) begin
			hold_until_drained();
			case (p)
			0: begin
				write_reg(CFG_DRIVE0, 8'h01);
				write_reg(CFG_DRIVE1, 8'h01);
				write_reg(CFG_POLLS, 8'd0);
			end
			1: begin
				write_reg(CFG_DRIVE0, 8'h00);
				write_reg(CFG_DRIVE1, 8'hFF);
				write_reg(CFG_POLLS, 8'd255);
			end
			2: begin
				write_reg(CFG_DRIVE0, 8'hFF);
				write_reg(CFG_DRIVE1, 8'h00);
				write_reg(CFG_POLLS, 8'd1);
			end
			3: begin
				write_reg(CFG_DRIVE0, 8'($urandom));
				write_reg(CFG_DRIVE1, 8'($urandom));
				write_reg(CFG_POLLS, 8'($urandom_range(0, 12)));
			end
			default: begin
				write_reg(CFG_DRIVE0, 8'h00);
				write_reg(CFG_DRIVE1, 8'h00);
				write_reg(CFG_POLLS, 8'd2);
			end
			endcase
			phase_end = N_PLAN + (p + 1) * 145;
			while (n_sent < phase_end)
				run_session();
		end

		hold_until_drained();
		$display("%0d words sent, %0d results checked, %0d transfers run to the end, %0d commits",
			n_sent, n_checked, n_xfer_done, n_commits);
		$display("five drive presence / busy poll settings after the directed table, polls 0..255");
		if (n_bad == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: ata_pio_task_file_controller.f
rtl/tfc_pkg.sv
rtl/tfc_if.sv
rtl/tfc_buffer.sv
rtl/tfc_regs.sv
rtl/ata_pio_task_file_controller.sv
tb/sv/tb_top.sv
